>>> hdl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared types and constants for the indexed list with insert and delete.
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int DATA_W        = 32;
    localparam int POS_W         = 5;
    localparam int COUNT_OUT_W   = 5;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] DEL_ERR_VALUE = {DATA_W{1'b1}};

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } ilid_cmd_t;

endpackage

>>> hdl/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// One list entry. Takes the new value, its left neighbor or its right
// neighbor, depending on the command and its own place in the chain.
// ----------------------------------------------------------------------------
module ilid_cell
    import ilid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  ilid_cmd_t         cmd,
    input  logic [DATA_W-1:0] left_value,
    input  logic [DATA_W-1:0] right_value,
    output logic [DATA_W-1:0] value,
    output logic [DATA_W-1:0] sel_value
);

    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W    = (IDX_BITS > POS_W) ? IDX_BITS : POS_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic [CMP_W-1:0]  pos_ext;
    logic              at_pos;
    logic              past_pos;

    assign pos_ext  = CMP_W'(cmd.pos);
    assign at_pos   = (MY_IDX == pos_ext);
    assign past_pos = (MY_IDX > pos_ext);

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (at_pos)
            begin
                value_next = cmd.data;
            end
            else if (past_pos)
            begin
                value_next = left_value;
            end
        end
        else if (cmd.del)
        begin
            if (at_pos || past_pos)
            begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    assign sel_value = at_pos ? value_reg : '0;

endmodule

>>> hdl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of signed 32-bit values kept in a chain of entry cells.
// Each item inserts at or deletes from a position and yields one result.
//
//  Channel  Signals                                      Direction
//  item     item_valid, item_stall, operation,           in
//           position, data_value
//  result   result_valid, result_stall, status,          out
//           removed_value, entry_count
//
// One item is taken per cycle unless stalled; cells from position on update.
// The result is registered and appears the cycle after the item is taken.
// Reset empties the list; entry contents are not cleared.
// An item is stalled only while a result is held and stalled downstream.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          operation,
    input  logic [POS_W-1:0]              position,
    input  logic signed [DATA_W-1:0]      data_value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [STATUS_W-1:0]           status,
    output logic signed [DATA_W-1:0]      removed_value,
    output logic [COUNT_OUT_W-1:0]        entry_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [DATA_W-1:0]   removed_reg;
    logic [DATA_W-1:0]   removed_next;

    logic              accept;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  count_ext;
    ilid_cmd_t         cmd;
    logic [DATA_W-1:0] cell_value [DEPTH];
    logic [DATA_W-1:0] cell_sel   [DEPTH];
    logic [DATA_W-1:0] picked_value;

    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign pos_ext    = CMP_W'(position);
    assign count_ext  = CMP_W'(count_reg);

    always_comb
    begin
        picked_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            picked_value = picked_value | cell_sel[i];
        end
    end

    always_comb
    begin
        cmd.ins           = 1'b0;
        cmd.del           = 1'b0;
        cmd.pos           = position;
        cmd.data          = data_value;
        count_next        = count_reg;
        status_next       = status_reg;
        removed_next      = removed_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (accept)
        begin
            result_valid_next = 1'b1;
            if (operation == OP_INSERT)
            begin
                removed_next = '0;
                if (pos_ext > count_ext)
                begin
                    status_next = ST_BOUND;
                end
                else if (count_ext == DEPTH_CMP)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_DONE;
                    cmd.ins     = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                if (pos_ext >= count_ext)
                begin
                    status_next  = ST_BOUND;
                    removed_next = DEL_ERR_VALUE;
                end
                else
                begin
                    status_next  = ST_DONE;
                    removed_next = picked_value;
                    cmd.del      = 1'b1;
                    count_next   = count_reg - 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;

        if (g == 0)
        begin : g_first
            assign left_value = data_value;
        end
        else
        begin : g_inner_left
            assign left_value = cell_value[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_value = cell_value[g];
        end
        else
        begin : g_inner_right
            assign right_value = cell_value[g+1];
        end

        ilid_cell #(
            .DEPTH (DEPTH),
            .INDEX (g)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[g]),
            .sel_value   (cell_sel[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign entry_count   = COUNT_OUT_W'(count_reg);

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= DEPTH_CMP)
        else $error("entry count exceeds list depth");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid_reg)
        else $error("accepted item produced no result");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_DELETE && pos_ext < count_ext)
        |=> (count_reg == $past(count_reg) - 1'b1) && status_reg == ST_DONE)
        else $error("successful delete did not shrink the list");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && status_reg == ST_FULL) |-> CMP_W'(count_reg) == DEPTH_CMP)
        else $error("list full reported while list is not full");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed list with insert and delete.
// A queue-based list model predicts status, removed value and entry count
// for every accepted item, and each result is checked against the oldest
// prediction. Directed cases cover the bounds, a full list and an empty
// list; random traffic follows under random idling and long back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import ilid_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD  = 80;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] removed;
        logic [COUNT_OUT_W-1:0]   count;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    logic                     operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
    logic                     result_valid;
    logic                     result_stall;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic [COUNT_OUT_W-1:0]   entry_count;

    logic signed [DATA_W-1:0] list_model[$];
    list_result_t             pending_results[$];
    list_result_t             expected_result;
    int                       mismatch_count = 0;
    int                       idle_cycles = 0;
    int                       burst_left = 0;
    bit                       no_gaps = 1'b0;
    bit                       long_hold_req = 1'b0;

    indexed_list_insert_delete #(.DEPTH(LIST_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .position     (position),
        .data_value   (data_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .removed_value(removed_value),
        .entry_count  (entry_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic list_result_t apply_list_op(input logic op, input logic [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] val);
        list_result_t r;
        r.status  = ST_DONE;
        r.removed = '0;
        if (op == OP_INSERT)
        begin
            if (pos > list_model.size())
                r.status = ST_BOUND;
            else if (list_model.size() >= LIST_DEPTH)
                r.status = ST_FULL;
            else
                list_model.insert(pos, val);
        end
        else
        begin
            if (pos >= list_model.size())
            begin
                r.status  = ST_BOUND;
                r.removed = DEL_ERR_VALUE;
            end
            else
            begin
                r.removed = list_model[pos];
                list_model.delete(pos);
            end
        end
        r.count = COUNT_OUT_W'(list_model.size());
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val);
        int gap;
        item_valid <= 1'b1;
        operation  <= op;
        position   <= pos;
        data_value <= val;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(apply_list_op(op, pos, val));
        burst_left--;
        if (!no_gaps && burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_list_op(input int insert_pct, input int noise_pct);
        int n;
        n = list_model.size();
        if ($urandom_range(0, 99) < noise_pct)
            send_item(1'($urandom_range(0, 1)), POS_W'($urandom_range(0, 31)), pick_value());
        else if (n == 0 || (n < LIST_DEPTH && $urandom_range(0, 99) < insert_pct))
            send_item(OP_INSERT, POS_W'($urandom_range(0, n)), pick_value());
        else
            send_item(OP_DELETE, POS_W'($urandom_range(0, n - 1)), pick_value());
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(OP_DELETE, 0, 32'sd5);
        send_item(OP_DELETE, 31, -32'sd1);
        send_item(OP_INSERT, 1, 32'sd9);
        send_item(OP_INSERT, 0, 32'sh7fff_ffff);
        send_item(OP_INSERT, 1, 32'sh8000_0000);
        send_item(OP_INSERT, 1, -32'sd1);
        send_item(OP_INSERT, 0, 32'sd0);
        while (list_model.size() < LIST_DEPTH)
            send_item(OP_INSERT, POS_W'($urandom_range(0, list_model.size())), $urandom);
        send_item(OP_INSERT, 16, 32'sd1);
        send_item(OP_INSERT, 31, 32'sd2);
        send_item(OP_DELETE, 16, 32'sd3);
        send_item(OP_DELETE, 15, 32'sd0);
        send_item(OP_DELETE, 0, 32'sd0);
        send_item(OP_DELETE, 7, 32'sd0);
    endtask

    task automatic test_full_list();
        while (list_model.size() < LIST_DEPTH)
            send_list_op(100, 0);
        repeat (6)
            send_item(OP_INSERT, POS_W'($urandom_range(0, 31)), pick_value());
        while (list_model.size() > 0)
            send_list_op(0, 0);
        repeat (4)
            send_item(OP_DELETE, POS_W'($urandom_range(0, 31)), pick_value());
    endtask

    task automatic test_backpressure();
        long_hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (40)
            send_list_op(60, 10);
        no_gaps = 1'b0;
        wait_drained();
        long_hold_req = 1'b0;
    endtask

    task automatic test_random_mix(input int count);
        int insert_pct;
        insert_pct = 75;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 39)
                insert_pct = 100 - insert_pct;
            send_list_op(insert_pct, 15);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        item_valid   <= 1'b0;
        operation    <= OP_INSERT;
        position     <= '0;
        data_value   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_backpressure();
        test_random_mix(360);
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int mode;
        int mode_cycles;
        bit hold_done;
        mode = 0;
        mode_cycles = 0;
        hold_done = 1'b0;
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                mode_cycles++;
                if (mode_cycles >= 50)
                begin
                    mode_cycles = 0;
                    mode = $urandom_range(0, 3);
                end
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 99) < 30);
                    2: result_stall <= ($urandom_range(0, 99) < 70);
                    default: result_stall <= (mode_cycles % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d %0d %0d",
                         $time, status, removed_value, entry_count);
                mismatch_count++;
            end
            else
            begin
                expected_result = pending_results.pop_front();
                if (status !== expected_result.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, expected_result.status, status);
                    mismatch_count++;
                end
                if (removed_value !== expected_result.removed)
                begin
                    $display("%0t: removed_value mismatch: expected %0d, actual %0d",
                             $time, expected_result.removed, removed_value);
                    mismatch_count++;
                end
                if (entry_count !== expected_result.count)
                begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, expected_result.count, entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
